[src/pspwm_pkg.sv]
// pspwm_pkg: shared types, widths and register indexes for the speed-loop PID.
// Used by every module of pid_speed_to_pwm; depends on nothing.
package pspwm_pkg;

   // PWM period default (counts)
   localparam int PWM_PERIOD_DEF = 4200;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W  = 35;
   localparam int MUL_B_W  = 18;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_SMOOTHING  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_SUM_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_TERM_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT      = 3'd6;

   // Register reset values
   localparam logic signed [15:0] PROP_GAIN_RST        = 16'sd1536;
   localparam logic signed [15:0] INTEG_GAIN_RST       = 16'sd128;
   localparam logic signed [15:0] DERIV_GAIN_RST       = 16'sd0;
   localparam logic [15:0]        DERIV_SMOOTHING_RST  = 16'd0;
   localparam logic [15:0]        INTEG_SUM_LIMIT_RST  = 16'd2000;
   localparam logic [14:0]        INTEG_TERM_LIMIT_RST = 15'd1000;
   localparam logic [14:0]        DRIVE_LIMIT_RST      = 15'd4200;

   // Width of the clamped P+I+D sum (Q.8)
   localparam int SUM_W = 24;

   // Current register settings
   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] integ_gain;
      logic signed [15:0] deriv_gain;
      logic [15:0]        deriv_smoothing;
      logic [15:0]        integ_sum_limit;
      logic [14:0]        integ_term_limit;
      logic [14:0]        drive_limit;
   } cfg_type;

   // Finished result from the sequencer to the output stage
   typedef struct packed {
      logic                    valid;
      logic                    sleep;
      logic signed [SUM_W-1:0] sum;
   } res_type;

endpackage

[src/pspwm_csr.sv]
// pspwm_csr: configuration register file for the speed-loop PID.
// Depends on pspwm_pkg for register indexes, reset values and cfg_type.
module pspwm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pspwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pspwm_pkg::CSR_DATA_W-1:0]    csr_data,
   output pspwm_pkg::cfg_type                  cfg
);

   pspwm_pkg::cfg_type cfg_ff, cfg_in;

   // always able to take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pspwm_pkg::CSR_PROP_GAIN:        cfg_in.prop_gain        = csr_data;
            pspwm_pkg::CSR_INTEG_GAIN:       cfg_in.integ_gain       = csr_data;
            pspwm_pkg::CSR_DERIV_GAIN:       cfg_in.deriv_gain       = csr_data;
            pspwm_pkg::CSR_DERIV_SMOOTHING:  cfg_in.deriv_smoothing  = csr_data;
            pspwm_pkg::CSR_INTEG_SUM_LIMIT:  cfg_in.integ_sum_limit  = csr_data;
            pspwm_pkg::CSR_INTEG_TERM_LIMIT: cfg_in.integ_term_limit = csr_data[14:0];
            pspwm_pkg::CSR_DRIVE_LIMIT:      cfg_in.drive_limit      = csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= pspwm_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain       <= pspwm_pkg::INTEG_GAIN_RST;
         cfg_ff.deriv_gain       <= pspwm_pkg::DERIV_GAIN_RST;
         cfg_ff.deriv_smoothing  <= pspwm_pkg::DERIV_SMOOTHING_RST;
         cfg_ff.integ_sum_limit  <= pspwm_pkg::INTEG_SUM_LIMIT_RST;
         cfg_ff.integ_term_limit <= pspwm_pkg::INTEG_TERM_LIMIT_RST;
         cfg_ff.drive_limit      <= pspwm_pkg::DRIVE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/pspwm_mul.sv]
// pspwm_mul: shared signed multiplier with a registered product.
// Depends on pspwm_pkg for operand widths.
module pspwm_mul (
   input  logic                                 clock,
   input  logic signed [pspwm_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [pspwm_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [pspwm_pkg::PROD_W-1:0]  prod
);

   logic signed [pspwm_pkg::PROD_W-1:0] prod_ff, prod_in;

   // full-width signed product
   assign prod_in = pspwm_pkg::PROD_W'(mul_a) * pspwm_pkg::PROD_W'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[src/pspwm_core.sv]
// pspwm_core: PID sequencer and datapath; drives the shared multiplier and
// keeps the loop state. Depends on pspwm_pkg (cfg_type, res_type, widths).
module pspwm_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic signed [15:0]                   req_measured_speed,
   input  logic signed [15:0]                   req_target_speed,
   input  pspwm_pkg::cfg_type                   cfg,
   input  logic                                 out_free,
   output pspwm_pkg::res_type                   res,
   output logic signed [pspwm_pkg::MUL_A_W-1:0] mul_a,
   output logic signed [pspwm_pkg::MUL_B_W-1:0] mul_b,
   input  logic signed [pspwm_pkg::PROD_W-1:0]  prod
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_P,
      S_I,
      S_D,
      S_F1,
      S_F2,
      S_F3,
      S_ACC,
      S_CLAMP,
      S_OUT
   } state_type;

   localparam int SUM_W = pspwm_pkg::SUM_W;
   localparam int ACC_W = 37;
   localparam int TMP_W = 52;
   localparam int PD_W  = 35;

   state_type                   state_ff, state_in;
   logic                        sleep_ff, sleep_in;
   logic signed [16:0]          err_ff, err_in;
   logic signed [17:0]          err_sum_ff, err_sum_in;
   logic signed [16:0]          prev_err_ff, prev_err_in;
   logic signed [PD_W-1:0]      prev_d_ff, prev_d_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [TMP_W-1:0]     tmp_ff, tmp_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;

   logic signed [16:0]                   err_raw;
   logic signed [18:0]                   es_raw, es_lim;
   logic signed [17:0]                   es_clamp;
   logic signed [pspwm_pkg::PROD_W-1:0]  ilim;
   logic signed [SUM_W-1:0]              iterm;
   logic signed [pspwm_pkg::PROD_W:0]    dsum;
   logic signed [ACC_W-1:0]              dlim;
   logic signed [SUM_W-1:0]              sum_clamp;
   logic signed [17:0]                   err_diff;

   assign req_stall = (state_ff != S_IDLE);

   assign res.valid = (state_ff == S_OUT);
   assign res.sleep = sleep_ff;
   assign res.sum   = sum_ff;

   // error, measured minus target
   assign err_raw  = 17'(req_measured_speed) - 17'(req_target_speed);
   assign err_diff = 18'(err_ff) - 18'(prev_err_ff);

   // error sum update with symmetric clamp
   assign es_raw = 19'(err_sum_ff) + 19'(err_ff);
   assign es_lim = {3'b000, cfg.integ_sum_limit};
   always_comb begin
      if (es_raw > es_lim)
         es_clamp = 18'(es_lim);
      else if (es_raw < -es_lim)
         es_clamp = 18'(-es_lim);
      else
         es_clamp = es_raw[17:0];
   end

   // I term clamp against integ_term_limit in Q.8
   assign ilim = {{(pspwm_pkg::PROD_W-23){1'b0}}, cfg.integ_term_limit, 8'h00};
   always_comb begin
      if (prod > ilim)
         iterm = SUM_W'(ilim);
      else if (prod < -ilim)
         iterm = SUM_W'(-ilim);
      else
         iterm = prod[SUM_W-1:0];
   end

   // filtered D: floor of the weighted sum over 2^16
   assign dsum = (pspwm_pkg::PROD_W+1)'(tmp_ff) + (pspwm_pkg::PROD_W+1)'(prod);

   // final clamp against drive_limit in Q.8
   assign dlim = {{(ACC_W-23){1'b0}}, cfg.drive_limit, 8'h00};
   always_comb begin
      if (acc_ff > dlim)
         sum_clamp = SUM_W'(dlim);
      else if (acc_ff < -dlim)
         sum_clamp = SUM_W'(-dlim);
      else
         sum_clamp = acc_ff[SUM_W-1:0];
   end

   // sequencer: operand select and next values
   always_comb begin
      state_in    = state_ff;
      sleep_in    = sleep_ff;
      err_in      = err_ff;
      err_sum_in  = err_sum_ff;
      prev_err_in = prev_err_ff;
      prev_d_in   = prev_d_ff;
      acc_in      = acc_ff;
      tmp_in      = tmp_ff;
      sum_in      = sum_ff;
      mul_a       = '0;
      mul_b       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in   = err_raw;
               sleep_in = req_kind;
               state_in = req_kind ? S_OUT : S_P;
            end
         end
         S_P: begin
            mul_a      = pspwm_pkg::MUL_A_W'(cfg.prop_gain);
            mul_b      = pspwm_pkg::MUL_B_W'(err_ff);
            err_sum_in = es_clamp;
            state_in   = S_I;
         end
         S_I: begin
            mul_a    = pspwm_pkg::MUL_A_W'(cfg.integ_gain);
            mul_b    = err_sum_ff;
            acc_in   = prod[ACC_W-1:0];
            state_in = S_D;
         end
         S_D: begin
            mul_a    = pspwm_pkg::MUL_A_W'(cfg.deriv_gain);
            mul_b    = err_diff;
            acc_in   = acc_ff + ACC_W'(iterm);
            state_in = S_F1;
         end
         S_F1: begin
            // raw D times (1 - smoothing)
            mul_a       = prod[pspwm_pkg::MUL_A_W-1:0];
            mul_b       = 18'(17'h10000 - {1'b0, cfg.deriv_smoothing});
            prev_err_in = err_ff;
            state_in    = S_F2;
         end
         S_F2: begin
            // previous D times smoothing
            mul_a    = prev_d_ff;
            mul_b    = {2'b00, cfg.deriv_smoothing};
            tmp_in   = prod[TMP_W-1:0];
            state_in = S_F3;
         end
         S_F3: begin
            prev_d_in = dsum[PD_W+15:16];
            state_in  = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_ff + ACC_W'(prev_d_ff);
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            sum_in   = sum_clamp;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free)
               state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         sleep_ff    <= 1'b0;
         err_sum_ff  <= '0;
         prev_err_ff <= '0;
         prev_d_ff   <= '0;
         sum_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         sleep_ff    <= sleep_in;
         err_sum_ff  <= err_sum_in;
         prev_err_ff <= prev_err_in;
         prev_d_ff   <= prev_d_in;
         sum_ff      <= sum_in;
      end
      err_ff <= err_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
   end

   // a control request starts the multiply chain on the next cycle
   a_ctrl_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_kind |=> state_ff == S_P)
      else $error("control request did not start the sequence");

   // a sleep request goes straight to the result slot without touching state
   a_sleep_state: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind |=> state_ff == S_OUT
         && $stable(err_sum_ff) && $stable(prev_err_ff) && $stable(prev_d_ff))
      else $error("sleep request disturbed loop state");

   // a held result keeps its sum until the output stage takes it
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      res.valid && !out_free |=> res.valid && $stable(res.sum) && $stable(res.sleep))
      else $error("result changed while the output stage was full");

endmodule

[src/pid_speed_to_pwm.sv]
// pid_speed_to_pwm: speed-loop PID controller with H-bridge compare mapping.
// Depends on pspwm_pkg, pspwm_csr, pspwm_mul and pspwm_core.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+----------------
//   request | req_kind, req_measured_speed, req_target_speed | req_valid/req_stall
//   result  | rsp_drive, rsp_compare_a, rsp_compare_b       | rsp_valid/rsp_stall
//   config  | csr_index, csr_data                          | csr_valid/csr_ready
//
// A control request steps from acceptance to a loaded result through P, I, D,
// F1, F2, F3, ACC and CLAMP: five products go one after another through the
// single shared multiplier, plus the filter, sum and clamp steps. A sleep
// request goes straight to the result state. One request is in flight at a
// time; req_stall is high until the result is handed to the output register,
// which holds it while rsp_stall is high; the next one is taken the cycle after.
// Synchronous reset restores the register defaults and clears the loop state.
module pid_speed_to_pwm #(
   parameter int PWM_PERIOD = pspwm_pkg::PWM_PERIOD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic signed [15:0]                   req_measured_speed,
   input  logic signed [15:0]                   req_target_speed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [13:0]                   rsp_drive,
   output logic [12:0]                          rsp_compare_a,
   output logic [12:0]                          rsp_compare_b,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pspwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pspwm_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam logic signed [17:0] PERIOD = 18'(PWM_PERIOD);

   pspwm_pkg::cfg_type                   cfg;
   pspwm_pkg::res_type                   res;
   logic signed [pspwm_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pspwm_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pspwm_pkg::PROD_W-1:0]  prod;

   logic                out_free, out_load;
   logic signed [24:0]  sum_bias;
   logic signed [17:0]  drv_trunc, drv, ca, cb;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [13:0]  drive_ff, drive_in;
   logic [12:0]         ca_ff, ca_in, cb_ff, cb_in;

   pspwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pspwm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   pspwm_core u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_measured_speed (req_measured_speed),
      .req_target_speed   (req_target_speed),
      .cfg                (cfg),
      .out_free           (out_free),
      .res                (res),
      .mul_a              (mul_a),
      .mul_b              (mul_b),
      .prod               (prod)
   );

   // output register takes a new result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = res.valid && out_free;

   // divide by 256 truncating toward zero
   assign sum_bias  = 25'($signed(res.sum))
                      + (res.sum[pspwm_pkg::SUM_W-1] ? 25'sd255 : 25'sd0);
   assign drv_trunc = 18'($signed(sum_bias[24:8]));

   // clamp to the PWM period and map to bridge compares
   always_comb begin
      if (drv_trunc > PERIOD)
         drv = PERIOD;
      else if (drv_trunc < -PERIOD)
         drv = -PERIOD;
      else
         drv = drv_trunc;
      if (drv > 18'sd0) begin
         ca = PERIOD;
         cb = PERIOD - drv;
      end else begin
         ca = PERIOD + drv;
         cb = PERIOD;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      drive_in     = drive_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (res.sleep) begin
            drive_in = '0;
            ca_in    = '0;
            cb_in    = '0;
         end else begin
            drive_in = drv[13:0];
            ca_in    = ca[12:0];
            cb_in    = cb[12:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      drive_ff <= drive_in;
      ca_ff    <= ca_in;
      cb_ff    <= cb_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_compare_a = ca_ff;
   assign rsp_compare_b = cb_ff;

   // a nonzero drive always leaves one bridge side at the full period
   a_bridge_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive != 14'sd0 |->
         rsp_compare_a == PERIOD[12:0] || rsp_compare_b == PERIOD[12:0])
      else $error("neither bridge compare sits at the period");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_compare_a) && $stable(rsp_compare_b))
      else $error("result changed while stalled");

   // a sleep request parks both bridge sides
   a_sleep_zero: assert property (@(posedge clock) disable iff (reset)
      out_load && res.sleep |=> rsp_drive == 14'sd0
         && rsp_compare_a == 13'd0 && rsp_compare_b == 13'd0)
      else $error("sleep request left a compare active");

endmodule
